// ----- rtl/utf16_to_utf7_encoder_macros.svh -----
// assertion macros used by the checker file
`ifndef UTF16_TO_UTF7_ENCODER_MACROS_SVH
`define UTF16_TO_UTF7_ENCODER_MACROS_SVH

// generic clocked assertion with asynchronous active-low reset
`define U7_ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// assertion on the block clock and reset
`define U7_ASSERT(label, prop, msg) \
  `U7_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// ----- rtl/u16u7_pkg.sv -----
`default_nettype none

package u16u7_pkg;

  // most bytes one code unit can produce
  localparam int unsigned MaxBytes = 5;
  localparam int unsigned NumW     = $clog2(MaxBytes + 1);

  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharMinus = 8'h2D;

  typedef logic [MaxBytes-1:0][7:0] byte_arr_t;

  // encoder state carried between units
  typedef struct packed {
    logic       run;
    logic [3:0] bits;
    logic [2:0] count;
  } enc_state_t;

  // bytes produced by one unit plus the state it leaves
  typedef struct packed {
    byte_arr_t       bytes;
    logic [NumW-1:0] num;
    enc_state_t      next;
  } enc_result_t;

  // set D characters plus space, tab, cr, lf
  function automatic logic is_direct(logic [15:0] c);
    logic [6:0] lo;
    logic       r;
    lo = c[6:0];
    r  = 1'b0;
    if (c[15:7] == 9'd0) begin
      r = lo inside {[7'h41:7'h5A], [7'h61:7'h7A], [7'h30:7'h39],
                     7'h27, 7'h28, 7'h29, 7'h2C, 7'h2D, 7'h2E, 7'h2F,
                     7'h3A, 7'h3F, 7'h20, 7'h09, 7'h0D, 7'h0A};
    end
    return r;
  endfunction

  // standard base64 alphabet
  function automatic logic [7:0] b64_char(logic [5:0] v);
    logic [7:0] r;
    if (v < 6'd26) begin
      r = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      r = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      r = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      r = CharPlus;
    end else begin
      r = 8'h2F;
    end
    return r;
  endfunction

  // write one byte into slot n of the burst
  function automatic byte_arr_t put_byte(byte_arr_t arr, logic [NumW-1:0] n,
                                         logic [7:0] b);
    byte_arr_t r;
    r = arr;
    if (n < NumW'(MaxBytes)) begin
      r[n] = b;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/u16u7_core.sv -----
`default_nettype none

// combinational encoding of one code unit into a burst of up to five bytes
module u16u7_core (
  input  logic [15:0]             code_unit_i,
  input  logic                    end_of_text_i,
  input  u16u7_pkg::enc_state_t   state_i,
  output u16u7_pkg::enc_result_t  result_o
);
  import u16u7_pkg::*;

  logic [19:0]     acc;
  byte_arr_t       bytes;
  logic [NumW-1:0] n;
  logic            run;
  logic [3:0]      pb;
  logic [2:0]      pc;
  logic [5:0]      flush_v;

  always_comb begin
    bytes = '0;
    n     = '0;
    run   = state_i.run;
    pb    = state_i.bits;
    pc    = state_i.count;
    acc   = {state_i.bits, code_unit_i};

    if (is_direct(code_unit_i)) begin
      // close an open run, then the character itself
      if (run) begin
        if (pc != 3'd0) begin
          flush_v = (pc == 3'd4) ? {pb, 2'b00} : {pb[1:0], 4'b0000};
          bytes   = put_byte(bytes, n, b64_char(flush_v));
          n       = n + NumW'(1);
        end
        bytes = put_byte(bytes, n, CharMinus);
        n     = n + NumW'(1);
        run   = 1'b0;
        pb    = 4'd0;
        pc    = 3'd0;
      end
      bytes = put_byte(bytes, n, code_unit_i[7:0]);
      n     = n + NumW'(1);
    end else if ((code_unit_i == 16'(CharPlus)) && !run) begin
      // escaped plus
      bytes = put_byte(bytes, n, CharPlus);
      n     = n + NumW'(1);
      bytes = put_byte(bytes, n, CharMinus);
      n     = n + NumW'(1);
    end else begin
      // open a run if needed
      if (!run) begin
        bytes = put_byte(bytes, n, CharPlus);
        n     = n + NumW'(1);
        run   = 1'b1;
        pb    = 4'd0;
        pc    = 3'd0;
        acc   = {4'd0, code_unit_i};
      end
      // append 16 bits and emit full sextets
      case (pc)
        3'd4: begin
          bytes = put_byte(bytes, n, b64_char(acc[19:14]));
          n     = n + NumW'(1);
          bytes = put_byte(bytes, n, b64_char(acc[13:8]));
          n     = n + NumW'(1);
          bytes = put_byte(bytes, n, b64_char(acc[7:2]));
          n     = n + NumW'(1);
          pb    = {2'b00, acc[1:0]};
          pc    = 3'd2;
        end
        3'd2: begin
          bytes = put_byte(bytes, n, b64_char(acc[17:12]));
          n     = n + NumW'(1);
          bytes = put_byte(bytes, n, b64_char(acc[11:6]));
          n     = n + NumW'(1);
          bytes = put_byte(bytes, n, b64_char(acc[5:0]));
          n     = n + NumW'(1);
          pb    = 4'd0;
          pc    = 3'd0;
        end
        default: begin
          bytes = put_byte(bytes, n, b64_char(acc[15:10]));
          n     = n + NumW'(1);
          bytes = put_byte(bytes, n, b64_char(acc[9:4]));
          n     = n + NumW'(1);
          pb    = acc[3:0];
          pc    = 3'd4;
        end
      endcase
    end

    // end of text closes an open run
    flush_v = (pc == 3'd4) ? {pb, 2'b00} : {pb[1:0], 4'b0000};
    if (end_of_text_i && run) begin
      if (pc != 3'd0) begin
        bytes = put_byte(bytes, n, b64_char(flush_v));
        n     = n + NumW'(1);
      end
      bytes = put_byte(bytes, n, CharMinus);
      n     = n + NumW'(1);
      run   = 1'b0;
      pb    = 4'd0;
      pc    = 3'd0;
    end

    result_o.bytes      = bytes;
    result_o.num        = n;
    result_o.next.run   = run;
    result_o.next.bits  = pb;
    result_o.next.count = pc;
  end

endmodule

`default_nettype wire

// ----- rtl/utf16_to_utf7_encoder.sv -----
// channel | direction | valid / stall           | payload
// --------+-----------+-------------------------+------------------------------
// in      | input     | in_valid_i / in_stall_o  | code_unit_i, end_of_text_i
// out     | output    | out_valid_o / out_stall_i| out_byte_o, last_of_item_o
//
// a code unit is encoded in the cycle it is accepted into a burst register;
// bytes leave one per cycle through the output register while the output is
// not stalled; a unit produces 1 to 5 bytes, 2 or 3 inside a base64 run.
// the next unit is accepted while the last byte of a burst moves out.
// reset clears the run state, the burst count and the output valid.
// a stalled output holds its byte; the input stalls while the burst is busy.
`default_nettype none

module utf16_to_utf7_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] code_unit_i,
  input  logic        end_of_text_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        last_of_item_o
);
  import u16u7_pkg::*;

  enc_state_t      st_q;
  enc_result_t     enc;
  byte_arr_t       burst_q, burst_d;
  logic [NumW-1:0] cnt_q, cnt_d;
  logic [7:0]      out_byte_q;
  logic            last_q;
  logic            out_valid_q;
  logic            out_free;
  logic            burst_pop;
  logic            in_take;

  u16u7_core u_core (
    .code_unit_i   (code_unit_i),
    .end_of_text_i (end_of_text_i),
    .state_i       (st_q),
    .result_o      (enc)
  );

  // handshake control
  assign out_free   = !out_valid_q || !out_stall_i;
  assign burst_pop  = (cnt_q != '0) && out_free;
  assign in_stall_o = !((cnt_q == '0) || ((cnt_q == NumW'(1)) && out_free));
  assign in_take    = in_valid_i && !in_stall_o;

  // burst next value
  always_comb begin
    burst_d = burst_q;
    cnt_d   = cnt_q;
    if (in_take) begin
      burst_d = enc.bytes;
      cnt_d   = enc.num;
    end else if (burst_pop) begin
      burst_d = byte_arr_t'(burst_q >> 8);
      cnt_d   = cnt_q - NumW'(1);
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (in_take) begin
        st_q <= enc.next;
      end
      if (burst_pop) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    burst_q <= burst_d;
    if (burst_pop) begin
      out_byte_q <= burst_q[0];
      last_q     <= (cnt_q == NumW'(1));
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_byte_q;
  assign last_of_item_o = last_q;

endmodule

`default_nettype wire

// ----- rtl/u16u7_checker.sv -----
`default_nettype none

`include "utf16_to_utf7_encoder_macros.svh"

// port-level checks of the encoder
module u16u7_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  out_byte_o,
  input logic        last_of_item_o
);

  logic [8:0] out_payload;

  // output fields seen as one word
  assign out_payload = {out_byte_o, last_of_item_o};

  // a stalled transaction stays offered
  `U7_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "out valid dropped")

  // a stalled transaction keeps its payload
  `U7_ASSERT(a_out_stable, out_valid_o && out_stall_i |=> $stable(out_payload), "out payload changed")

  // an accepted unit shows a byte after the burst register and the output register
  `U7_ASSERT(a_in_to_out, in_valid_i && !in_stall_o |-> ##2 out_valid_o, "no output after input")

  // a burst continues without a gap until its last byte
  `U7_ASSERT(a_burst_gapless, out_valid_o && !out_stall_i && !last_of_item_o |=> out_valid_o, "gap inside burst")

  // input cannot be taken while a stalled burst is unfinished
  `U7_ASSERT(a_in_blocked, out_valid_o && out_stall_i && !last_of_item_o |-> in_stall_o, "input taken mid burst")

endmodule

bind utf16_to_utf7_encoder u16u7_checker u_checker (.*);

`default_nettype wire
